// File: sv/lsb_stego_extractor_top_defines.svh
// Assertion macros used by the stego extractor checker.
`ifndef LSB_STEGO_EXTRACTOR_TOP_DEFINES_SVH
`define LSB_STEGO_EXTRACTOR_TOP_DEFINES_SVH

// Implication checked in the same cycle, masked during reset.
`define LSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, masked during reset.
`define LSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, active through reset.
`define LSE_ASSERT_NEXT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/lse_pkg.sv
// Shared types and constants for the LSB stego extractor.
`default_nettype none
package lse_pkg;

    localparam int MAX_MAGIC_LEN_DEF = 8;
    localparam int LENGTH_BITS_DEF   = 32;

    localparam int CNT_W  = 32;
    localparam int BIDX_W = 5;
    localparam int APB_AW = 5;
    localparam int APB_DW = 64;

    localparam logic [7:0]  HEADER_SKIP_RST = 8'd54;
    localparam logic [63:0] MAGIC_WORD_RST  = 64'd8989;
    localparam logic [3:0]  MAGIC_LEN_RST   = 4'd2;

    localparam logic [1:0] REG_HEADER_SKIP = 2'd0;
    localparam logic [1:0] REG_MAGIC_WORD  = 2'd1;
    localparam logic [1:0] REG_MAGIC_LEN   = 2'd2;

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_MAGIC,
        PH_EXT_LEN,
        PH_EXT,
        PH_PAY_LEN,
        PH_PAY,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        KIND_EXT_CHAR = 3'd0,
        KIND_PAY_BYTE = 3'd1,
        KIND_EXT_LEN  = 3'd2,
        KIND_PAY_LEN  = 3'd3,
        KIND_MISMATCH = 3'd4
    } t_kind;

    typedef struct packed {
        logic [7:0]  header_skip;
        logic [63:0] magic_word;
        logic [3:0]  magic_len;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] value;
        logic        last;
    } t_result;

endpackage
`default_nettype wire

// File: sv/lsb_stego_extractor_top.sv
// Top level of the LSB stego extractor.
// An accepted word is registered; its result, if any, is then buffered for the output.
// Throughput: one image word per cycle while the input is not stalled.
// Input stalls only while a word is held and the two-entry result buffer is full.
// Reset (synchronous, active low) restores default registers and the header skip phase.
`default_nettype none
module lsb_stego_extractor_top #(
    parameter int MAX_MAGIC_LEN = lse_pkg::MAX_MAGIC_LEN_DEF,
    parameter int LENGTH_BITS   = lse_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [7:0]                 i_pixel_byte,
    input  wire logic                       i_new_image,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic      [2:0]                 o_kind,
    output logic      [31:0]                o_value,
    output logic                            o_last,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [lse_pkg::APB_AW-1:0] paddr,
    input  wire logic [lse_pkg::APB_DW-1:0] pwdata,
    output logic      [lse_pkg::APB_DW-1:0] prdata,
    output logic                            pready
);

    lse_pkg::t_cfg    cfg;
    lse_pkg::t_result parse_res;
    lse_pkg::t_result out_res;
    logic             parse_push;
    logic             fifo_full;
    logic             proc;
    logic             accept;

    logic r_in_valid, n_in_valid;
    logic r_in_bit;
    logic r_in_new;

    assign o_in_stall = r_in_valid & fifo_full;
    assign accept     = i_in_valid & ~o_in_stall;
    assign proc       = r_in_valid & ~fifo_full;
    assign n_in_valid = accept | (r_in_valid & ~proc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_bit <= i_pixel_byte[0];
            r_in_new <= i_new_image;
        end
    end

    lse_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lse_parser #(
        .MAX_MAGIC_LEN (MAX_MAGIC_LEN),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_proc      (proc),
        .i_bit       (r_in_bit),
        .i_new_image (r_in_new),
        .i_cfg       (cfg),
        .o_push      (parse_push),
        .o_result    (parse_res)
    );

    lse_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (parse_push & proc),
        .i_data  (parse_res),
        .i_pop   (~i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (out_res),
        .o_full  (fifo_full)
    );

    assign o_kind  = out_res.kind;
    assign o_value = out_res.value;
    assign o_last  = out_res.last;

endmodule
`default_nettype wire

// File: sv/lse_cfg.sv
// APB register file holding the extractor configuration.
`default_nettype none
module lse_cfg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [lse_pkg::APB_AW-1:0] paddr,
    input  wire logic [lse_pkg::APB_DW-1:0] pwdata,
    output logic      [lse_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    output lse_pkg::t_cfg                   o_cfg
);

    lse_pkg::t_cfg r_cfg;
    logic [1:0]    reg_sel;
    logic          wr_en;

    assign reg_sel = paddr[4:3];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_skip <= lse_pkg::HEADER_SKIP_RST;
            r_cfg.magic_word  <= lse_pkg::MAGIC_WORD_RST;
            r_cfg.magic_len   <= lse_pkg::MAGIC_LEN_RST;
        end else if (wr_en) begin
            case (reg_sel)
                lse_pkg::REG_HEADER_SKIP: r_cfg.header_skip <= pwdata[7:0];
                lse_pkg::REG_MAGIC_WORD:  r_cfg.magic_word  <= pwdata;
                lse_pkg::REG_MAGIC_LEN:   r_cfg.magic_len   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            lse_pkg::REG_HEADER_SKIP: prdata = {56'd0, r_cfg.header_skip};
            lse_pkg::REG_MAGIC_WORD:  prdata = r_cfg.magic_word;
            lse_pkg::REG_MAGIC_LEN:   prdata = {60'd0, r_cfg.magic_len};
            default:                  prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: sv/lse_parser.sv
// Parse state machine: one hidden bit per word, emits decoded fields.
`default_nettype none
module lse_parser #(
    parameter int MAX_MAGIC_LEN = lse_pkg::MAX_MAGIC_LEN_DEF,
    parameter int LENGTH_BITS   = lse_pkg::LENGTH_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_proc,
    input  wire logic          i_bit,
    input  wire logic          i_new_image,
    input  wire lse_pkg::t_cfg i_cfg,
    output logic               o_push,
    output lse_pkg::t_result   o_result
);

    localparam logic [lse_pkg::BIDX_W:0] LEN_WIDTH = (lse_pkg::BIDX_W+1)'(LENGTH_BITS);
    localparam logic [lse_pkg::BIDX_W:0] CHR_WIDTH = (lse_pkg::BIDX_W+1)'(8);
    localparam logic [3:0]               MAX_LEN   = 4'(MAX_MAGIC_LEN);

    lse_pkg::t_phase              r_phase,  n_phase;
    logic [lse_pkg::BIDX_W-1:0]   r_bidx,   n_bidx;
    logic [LENGTH_BITS-1:0]       r_gather, n_gather;
    logic [lse_pkg::CNT_W-1:0]    r_cnt,    n_cnt;
    logic [31:0]                  r_runlen, n_runlen;
    logic                         r_mism,   n_mism;

    lse_pkg::t_phase              s_phase;
    logic [lse_pkg::BIDX_W-1:0]   s_bidx;
    logic [LENGTH_BITS-1:0]       s_gather;
    logic [lse_pkg::CNT_W-1:0]    s_cnt;
    logic [31:0]                  s_runlen;
    logic                         s_mism;

    logic                         skipping;
    logic [lse_pkg::BIDX_W:0]     bidx_inc;
    logic                         full;
    logic [LENGTH_BITS-1:0]       shifted;
    logic [7:0]                   ch;
    logic [31:0]                  len_eff;
    logic [lse_pkg::CNT_W-1:0]    cnt_inc;
    logic [3:0]                   mlen;
    logic [2:0]                   byte_sel;
    logic [7:0]                   expect_ch;
    logic                         mism_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= lse_pkg::PH_SKIP;
            r_bidx   <= '0;
            r_gather <= '0;
            r_cnt    <= '0;
            r_runlen <= '0;
            r_mism   <= 1'b0;
        end else if (i_proc) begin
            r_phase  <= n_phase;
            r_bidx   <= n_bidx;
            r_gather <= n_gather;
            r_cnt    <= n_cnt;
            r_runlen <= n_runlen;
            r_mism   <= n_mism;
        end
    end

    always_comb begin
        // restart on new image
        if (i_new_image) begin
            s_phase  = lse_pkg::PH_SKIP;
            s_bidx   = '0;
            s_gather = '0;
            s_cnt    = '0;
            s_runlen = '0;
            s_mism   = 1'b0;
        end else begin
            s_phase  = r_phase;
            s_bidx   = r_bidx;
            s_gather = r_gather;
            s_cnt    = r_cnt;
            s_runlen = r_runlen;
            s_mism   = r_mism;
        end

        skipping = 1'b0;
        if (s_phase == lse_pkg::PH_SKIP) begin
            if (s_cnt < lse_pkg::CNT_W'(i_cfg.header_skip)) begin
                skipping = 1'b1;
            end else begin
                s_phase  = lse_pkg::PH_MAGIC;
                s_cnt    = '0;
                s_bidx   = '0;
                s_gather = '0;
            end
        end

        bidx_inc = {1'b0, s_bidx} + 1'b1;
        if (s_phase == lse_pkg::PH_EXT_LEN || s_phase == lse_pkg::PH_PAY_LEN) begin
            full = bidx_inc >= LEN_WIDTH;
        end else begin
            full = bidx_inc >= CHR_WIDTH;
        end
        shifted = {s_gather[LENGTH_BITS-2:0], i_bit};
        ch      = shifted[7:0];
        len_eff = shifted[LENGTH_BITS-1] ? 32'd0 : 32'(shifted);
        cnt_inc = s_cnt + 1'b1;

        if (i_cfg.magic_len == 4'd0) begin
            mlen = 4'd1;
        end else if (i_cfg.magic_len > MAX_LEN) begin
            mlen = MAX_LEN;
        end else begin
            mlen = i_cfg.magic_len;
        end
        byte_sel = 3'(mlen - 4'd1 - s_cnt[3:0]);
        if (s_cnt < lse_pkg::CNT_W'(mlen)) begin
            expect_ch = i_cfg.magic_word[8*byte_sel +: 8];
        end else begin
            expect_ch = 8'd0;
        end
        mism_next = s_mism | (ch != expect_ch);

        n_phase  = s_phase;
        n_bidx   = s_bidx;
        n_gather = s_gather;
        n_cnt    = s_cnt;
        n_runlen = s_runlen;
        n_mism   = s_mism;
        o_push   = 1'b0;
        o_result = '{kind: lse_pkg::KIND_EXT_CHAR, value: 32'd0, last: 1'b0};

        if (skipping) begin
            n_cnt = cnt_inc;
        end else if (s_phase != lse_pkg::PH_DONE && s_phase != lse_pkg::PH_SKIP) begin
            if (!full) begin
                n_gather = shifted;
                n_bidx   = bidx_inc[lse_pkg::BIDX_W-1:0];
            end else begin
                n_gather = '0;
                n_bidx   = '0;
                case (s_phase)
                    lse_pkg::PH_MAGIC: begin
                        n_mism = mism_next;
                        if (cnt_inc >= lse_pkg::CNT_W'(mlen)) begin
                            n_cnt = '0;
                            if (mism_next) begin
                                n_phase  = lse_pkg::PH_DONE;
                                o_push   = 1'b1;
                                o_result = '{kind: lse_pkg::KIND_MISMATCH, value: 32'd0,
                                             last: 1'b1};
                            end else begin
                                n_phase = lse_pkg::PH_EXT_LEN;
                            end
                        end else begin
                            n_cnt = cnt_inc;
                        end
                    end
                    lse_pkg::PH_EXT_LEN: begin
                        n_runlen = len_eff;
                        n_cnt    = '0;
                        n_phase  = (len_eff != 32'd0) ? lse_pkg::PH_EXT : lse_pkg::PH_PAY_LEN;
                        o_push   = 1'b1;
                        o_result = '{kind: lse_pkg::KIND_EXT_LEN, value: len_eff, last: 1'b0};
                    end
                    lse_pkg::PH_EXT: begin
                        if (cnt_inc >= s_runlen) begin
                            n_cnt   = '0;
                            n_phase = lse_pkg::PH_PAY_LEN;
                        end else begin
                            n_cnt = cnt_inc;
                        end
                        o_push   = 1'b1;
                        o_result = '{kind: lse_pkg::KIND_EXT_CHAR, value: {24'd0, ch},
                                     last: 1'b0};
                    end
                    lse_pkg::PH_PAY_LEN: begin
                        n_runlen = len_eff;
                        n_cnt    = '0;
                        n_phase  = (len_eff != 32'd0) ? lse_pkg::PH_PAY : lse_pkg::PH_DONE;
                        o_push   = 1'b1;
                        o_result = '{kind: lse_pkg::KIND_PAY_LEN, value: len_eff,
                                     last: (len_eff == 32'd0)};
                    end
                    lse_pkg::PH_PAY: begin
                        n_cnt  = cnt_inc;
                        o_push = 1'b1;
                        if (cnt_inc >= s_runlen) begin
                            n_phase  = lse_pkg::PH_DONE;
                            o_result = '{kind: lse_pkg::KIND_PAY_BYTE, value: {24'd0, ch},
                                         last: 1'b1};
                        end else begin
                            o_result = '{kind: lse_pkg::KIND_PAY_BYTE, value: {24'd0, ch},
                                         last: 1'b0};
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

// File: sv/lse_out_fifo.sv
// Two-entry result buffer between the parser and the output port.
`default_nettype none
module lse_out_fifo (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire lse_pkg::t_result i_data,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output lse_pkg::t_result      o_data,
    output logic                  o_full
);

    lse_pkg::t_result r_mem [2];
    logic             r_wptr, n_wptr;
    logic             r_rptr, n_rptr;
    logic [1:0]       r_count, n_count;
    logic             do_pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_mem[r_rptr];
    assign do_pop  = i_pop & o_valid;

    always_comb begin
        n_wptr  = i_push ? ~r_wptr : r_wptr;
        n_rptr  = do_pop ? ~r_rptr : r_rptr;
        n_count = r_count + {1'b0, i_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// File: sv/lse_checker.sv
// Port-level assertions for the LSB stego extractor, bound to the top level.
`default_nettype none
`include "lsb_stego_extractor_top_defines.svh"
module lse_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [2:0]  o_kind,
    input wire logic [31:0] o_value,
    input wire logic        o_last
);

    `LSE_ASSERT_NEXT_RST(a_reset_clears_out, !i_rst_n, !o_out_valid,
        "output valid after reset")

    `LSE_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_value) && $stable(o_kind) && $stable(o_last),
        "stalled output word changed")

    `LSE_ASSERT_NOW(a_mismatch_form, o_out_valid && o_kind == lse_pkg::KIND_MISMATCH,
        o_value == 32'd0 && o_last, "mismatch word malformed")

    `LSE_ASSERT_NOW(a_char_form, o_out_valid && (o_kind == lse_pkg::KIND_EXT_CHAR ||
        o_kind == lse_pkg::KIND_PAY_BYTE), o_value[31:8] == 24'd0,
        "character word wider than a byte")

endmodule

bind lsb_stego_extractor_top lse_checker u_lse_checker (.*);
`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for lsb_stego_extractor_top: streams images, predicts decoded results.
`timescale 1ns / 100ps

module tb;
    import lse_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [7:0] pix;
        logic       nimg;
    } t_word;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  pix_d = 8'd0;
    logic        nimg_d = 1'b0;
    logic        out_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;

    wire               in_stall;
    wire               out_valid;
    wire [2:0]         kind;
    wire [31:0]        value;
    wire               last;
    wire [APB_DW-1:0]  prdata;
    wire               pready;

    // decoder state and register copy
    t_phase      img_phase;
    logic [4:0]  bit_pos;
    logic [31:0] shreg;
    logic [31:0] field_cnt;
    logic [31:0] run_len;
    logic        magic_bad;
    logic [7:0]  cfg_skip;
    logic [63:0] cfg_magic;
    logic [3:0]  cfg_mlen;

    t_word   image_q[$];
    t_result decoded_q[$];
    logic    img_first = 1'b0;
    logic    drain_hold = 1'b0;
    int      stim_cnt = 0;
    int      fail_cnt = 0;
    int      quiet = 0;
    int      snd_idle_pct = 25;
    int      rcv_idle_pct = 84;

    lsb_stego_extractor_top DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_pixel_byte (pix_d),
        .i_new_image  (nimg_d),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_kind       (kind),
        .o_value      (value),
        .o_last       (last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #1 clk = ~clk;

    function automatic int magic_len_eff();
        if (cfg_mlen == 4'd0) return 1;
        if (cfg_mlen > MAX_MAGIC_LEN_DEF) return MAX_MAGIC_LEN_DEF;
        return int'(cfg_mlen);
    endfunction

    function automatic void clear_parse();
        img_phase = PH_SKIP;
        bit_pos = '0;
        shreg = '0;
        field_cnt = '0;
        run_len = '0;
        magic_bad = 1'b0;
    endfunction

    function automatic bit shift_in(input logic hid, input int width);
        shreg = {shreg[30:0], hid};
        if (bit_pos + 1 >= width) begin
            bit_pos = '0;
            return 1'b1;
        end
        bit_pos = bit_pos + 5'd1;
        return 1'b0;
    endfunction

    function automatic bit decode_byte(input t_word w, output t_result res);
        int unsigned mlen;
        logic [7:0] ch;
        logic [7:0] want;
        res.kind = KIND_EXT_CHAR;
        res.value = '0;
        res.last = 1'b0;
        if (w.nimg) clear_parse();
        if (img_phase == PH_SKIP) begin
            if (field_cnt < cfg_skip) begin
                field_cnt++;
                return 1'b0;
            end
            img_phase = PH_MAGIC;
            field_cnt = '0;
            bit_pos = '0;
            shreg = '0;
        end
        case (img_phase)
            PH_MAGIC: begin
                if (!shift_in(w.pix[0], 8)) return 1'b0;
                mlen = magic_len_eff();
                ch = shreg[7:0];
                want = (field_cnt < mlen) ?
                       8'(cfg_magic >> (8 * (mlen - 1 - field_cnt))) : 8'h00;
                if (ch != want) magic_bad = 1'b1;
                shreg = '0;
                if (field_cnt + 1 < mlen) begin
                    field_cnt++;
                    return 1'b0;
                end
                field_cnt = '0;
                if (!magic_bad) begin
                    img_phase = PH_EXT_LEN;
                    return 1'b0;
                end
                img_phase = PH_DONE;
                res.kind = KIND_MISMATCH;
                res.last = 1'b1;
                return 1'b1;
            end
            PH_EXT_LEN, PH_PAY_LEN: begin
                if (!shift_in(w.pix[0], LENGTH_BITS_DEF)) return 1'b0;
                run_len = shreg[31] ? 32'd0 : shreg;
                shreg = '0;
                field_cnt = '0;
                res.value = run_len;
                if (img_phase == PH_EXT_LEN) begin
                    res.kind = KIND_EXT_LEN;
                    img_phase = (run_len != 0) ? PH_EXT : PH_PAY_LEN;
                end else begin
                    res.kind = KIND_PAY_LEN;
                    res.last = (run_len == 0);
                    img_phase = (run_len != 0) ? PH_PAY : PH_DONE;
                end
                return 1'b1;
            end
            PH_EXT, PH_PAY: begin
                if (!shift_in(w.pix[0], 8)) return 1'b0;
                res.value = {24'd0, shreg[7:0]};
                shreg = '0;
                field_cnt++;
                if (img_phase == PH_EXT) begin
                    res.kind = KIND_EXT_CHAR;
                    if (field_cnt >= run_len) begin
                        field_cnt = '0;
                        img_phase = PH_PAY_LEN;
                    end
                end else begin
                    res.kind = KIND_PAY_BYTE;
                    if (field_cnt >= run_len) begin
                        img_phase = PH_DONE;
                        res.last = 1'b1;
                    end
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // input side: hold while stalled, otherwise pop or idle
    always @(posedge clk) begin : feed
        t_word   w;
        t_result r;
        logic    send;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                w.pix = pix_d;
                w.nimg = nimg_d;
                if (decode_byte(w, r)) decoded_q.push_back(r);
            end
            if (!(in_valid && in_stall)) begin
                if (drain_hold && decoded_q.size() == 0) drain_hold = 1'b0;
                send = image_q.size() != 0 && !drain_hold &&
                       $urandom_range(0, 99) >= snd_idle_pct;
                if (send) begin
                    w = image_q.pop_front();
                    pix_d <= w.pix;
                    nimg_d <= w.nimg;
                    if ($urandom_range(0, 249) == 0) drain_hold = 1'b1;
                end
                in_valid <= send;
            end
        end
    end

    always @(posedge clk) begin : check
        t_result want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected result: kind %0d value 0x%0h last %0d", kind, value, last);
                    fail_cnt++;
                end else begin
                    want = decoded_q.pop_front();
                    if (kind !== want.kind) begin
                        $error("kind: expected %0d, actual %0d", want.kind, kind);
                        fail_cnt++;
                    end
                    if (value !== want.value) begin
                        $error("value: expected 0x%0h, actual 0x%0h", want.value, value);
                        fail_cnt++;
                    end
                    if (last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, last);
                        fail_cnt++;
                    end
                end
            end
            out_stall <= $urandom_range(0, 99) < rcv_idle_pct;
        end
    end

    always @(posedge clk) begin : watchdog
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("** lsb_stego_extractor_top: FAILED **");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [63:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_HEADER_SKIP: cfg_skip = data[7:0];
            REG_MAGIC_WORD:  cfg_magic = data;
            REG_MAGIC_LEN:   cfg_mlen = data[3:0];
            default: ;
        endcase
    endtask

    task automatic set_cfg(input logic [7:0] skip, input logic [63:0] mw, input logic [3:0] ml);
        reg_write(REG_HEADER_SKIP, {56'd0, skip});
        reg_write(REG_MAGIC_WORD, mw);
        reg_write(REG_MAGIC_LEN, {60'd0, ml});
    endtask

    // block is idle once all words are in and every result has come out
    task automatic wait_drained();
        while (image_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void begin_image();
        img_first = 1'b1;
    endfunction

    function automatic void push_word(input logic hid);
        logic [7:0] b;
        b = 8'($urandom);
        b[0] = hid;
        image_q.push_back(t_word'{b, img_first});
        img_first = 1'b0;
        stim_cnt++;
    endfunction

    function automatic void push_bits(input logic [31:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) push_word(v[i]);
    endfunction

    function automatic void push_skip(input int n);
        repeat (n) push_word(1'($urandom_range(0, 1)));
    endfunction

    // first n magic characters, first character from the highest used byte
    function automatic void push_magic(input logic [63:0] mw, input int n);
        int mlen;
        mlen = magic_len_eff();
        for (int i = 0; i < n; i++) push_bits(32'(mw >> (8 * (mlen - 1 - i))), 8);
    endfunction

    function automatic void push_body(input logic [31:0] ext_raw, input int n_ext,
                                      input logic [31:0] pay_raw, input int n_pay);
        push_bits(ext_raw, 32);
        repeat (n_ext) push_bits($urandom, 8);
        push_bits(pay_raw, 32);
        repeat (n_pay) push_bits($urandom, 8);
    endfunction

    // trailing words after the end of an image are ignored
    function automatic void push_tail(input int n);
        logic [7:0] b;
        repeat (n) begin
            b = 8'($urandom);
            image_q.push_back(t_word'{b, 1'b0});
        end
    endfunction

    function automatic void full_image(input logic [31:0] ext_raw, input int n_ext,
                                       input logic [31:0] pay_raw, input int n_pay,
                                       input int tail);
        begin_image();
        push_skip(cfg_skip);
        push_magic(cfg_magic, magic_len_eff());
        push_body(ext_raw, n_ext, pay_raw, n_pay);
        push_tail(tail);
    endfunction

    task automatic pick_len(input int n_max, output logic [31:0] raw, output int n);
        logic [31:0] rnd;
        rnd = $urandom;
        n = $urandom_range(0, n_max);
        raw = n;
        if ($urandom_range(0, 7) == 0) begin
            raw = {1'b1, rnd[30:0]};
            n = 0;
        end
    endtask

    task automatic rand_cfg();
        int r;
        logic [3:0] ml;
        r = $urandom_range(0, 9);
        if (r == 0) ml = 4'd0;
        else if (r == 1) ml = 4'($urandom_range(9, 15));
        else ml = 4'($urandom_range(1, 8));
        set_cfg(8'($urandom_range(0, 6)), {$urandom, $urandom}, ml);
    endtask

    // mostly well-formed images; some bad magic, some cut short, some noise
    task automatic rand_image();
        int r;
        int mark;
        int cut;
        int n_ext;
        int n_pay;
        logic [31:0] ext_raw;
        logic [31:0] pay_raw;
        logic [63:0] mw;
        r = $urandom_range(0, 99);
        begin_image();
        if (r >= 92) begin
            repeat ($urandom_range(10, 60)) begin
                if ($urandom_range(0, 29) == 0) begin_image();
                push_word(1'($urandom_range(0, 1)));
            end
            return;
        end
        mark = image_q.size();
        mw = cfg_magic;
        if (r >= 75 && r < 84) mw ^= 64'd1 << $urandom_range(0, 8 * magic_len_eff() - 1);
        push_skip(cfg_skip);
        push_magic(mw, magic_len_eff());
        if (r >= 75 && r < 84) begin
            push_tail($urandom_range(0, 3));
            return;
        end
        pick_len(3, ext_raw, n_ext);
        pick_len(($urandom_range(0, 9) == 0) ? 30 : 8, pay_raw, n_pay);
        push_body(ext_raw, n_ext, pay_raw, n_pay);
        if (r >= 84) begin
            cut = $urandom_range(1, image_q.size() - mark - 1);
            stim_cnt -= image_q.size() - mark - cut;
            while (image_q.size() > mark + cut) void'(image_q.pop_back());
        end else begin
            push_tail($urandom_range(0, 3));
        end
    endtask

    initial begin : stimulus
        int img_n;
        int phase_end;
        img_n = 0;
        clear_parse();
        cfg_skip = HEADER_SKIP_RST;
        cfg_magic = MAGIC_WORD_RST;
        cfg_mlen = MAGIC_LEN_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset registers
        full_image(32'd2, 2, 32'd3, 3, 2);
        wait_drained();
        // zero extension and payload lengths
        set_cfg(8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
        full_image(32'd0, 0, 32'd0, 0, 3);
        wait_drained();
        // longest header, lengths with top bit set
        set_cfg(8'd255, 64'd0, 4'd1);
        full_image(32'hFFFF_FFFF, 0, 32'h8000_0001, 0, 1);
        wait_drained();
        // magic length zero, bad magic, restart mid-image
        set_cfg(8'd3, {$urandom, $urandom}, 4'd0);
        full_image(32'd1, 1, 32'd2, 2, 0);
        begin_image();
        push_skip(cfg_skip);
        push_magic(cfg_magic ^ 64'd1, magic_len_eff());
        push_tail(4);
        begin_image();
        push_skip(cfg_skip);
        push_magic(cfg_magic, magic_len_eff());
        push_bits(32'd0, 20);
        full_image(32'd0, 0, 32'd1, 1, 0);
        wait_drained();
        // magic length above maximum
        reg_write(REG_MAGIC_LEN, 64'd15);
        full_image(32'd3, 3, 32'd2, 2, 1);
        wait_drained();
        // magic length lowered in the middle of the magic check
        set_cfg(8'd1, {$urandom, $urandom}, 4'd4);
        begin_image();
        push_skip(cfg_skip);
        push_magic(cfg_magic, 2);
        wait_drained();
        reg_write(REG_MAGIC_LEN, 64'd2);
        push_bits(32'd0, 8);
        push_body(32'd2, 2, 32'd1, 1);
        push_tail(1);
        wait_drained();

        for (int m = 0; m < 3; m++) begin
            snd_idle_pct = (m == 0) ? 25 : (m == 1) ? 84 : 0;
            rcv_idle_pct = (m == 0) ? 84 : (m == 1) ? 25 : 0;
            phase_end = stim_cnt + 100;
            while (stim_cnt < phase_end) begin
                if (img_n % 2 == 0) begin
                    wait_drained();
                    rand_cfg();
                end
                rand_image();
                img_n++;
            end
        end

        wait_drained();
        if (fail_cnt == 0 && decoded_q.size() == 0) begin
            $display("** lsb_stego_extractor_top: PASSED **");
        end else begin
            $display("** lsb_stego_extractor_top: FAILED **");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/lse_pkg.sv
sv/lse_cfg.sv
sv/lse_parser.sv
sv/lse_out_fifo.sv
sv/lsb_stego_extractor_top.sv
sv/lse_checker.sv
dv/tb.sv
